// ===== rtl/core/tgi_pkg.sv =====
// Shared types and constants for the trilinear grid interpolator.
package tgi_pkg;

  localparam int unsigned MAX_X_DEF       = 16;
  localparam int unsigned MAX_Y_DEF       = 16;
  localparam int unsigned MAX_Z_DEF       = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned LOAD_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(16);
  localparam logic [INV_W-1:0]  INV_RST  = INV_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_INV_X  = 3'd3,
    REG_INV_Y  = 3'd4,
    REG_INV_Z  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

endpackage

// ===== rtl/core/tgi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tgi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tgi_axis.sv =====
// One axis of the front end: scale by reciprocal, clip, split into index and fraction.
// Two stages: product register, then clipped index and fraction register.
module tgi_axis #(
  parameter int unsigned MAXN      = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tgi_pkg::COORD_W-1:0]  coord,
  input  logic [tgi_pkg::INV_W-1:0]           inv,
  input  logic [tgi_pkg::SIZE_W-1:0]          size,
  output logic [$clog2(MAXN)-1:0]             idx,
  output logic [FRAC_BITS:0]                  frac
);
  import tgi_pkg::*;

  localparam int unsigned IW  = $clog2(MAXN);
  localparam int unsigned PW  = COORD_W + INV_W;
  localparam int unsigned SH  = 32 - FRAC_BITS;
  localparam int unsigned QW  = PW - SH;
  localparam int unsigned EW  = (SIZE_W > IW + 1) ? SIZE_W : IW + 1;

  logic [PW-1:0]  prod_r;
  logic [EW-1:0]  sz1_r;
  logic [QW-1:0]  pos;
  logic [QW-1:0]  top;
  logic [QW-1:0]  clip;
  logic [EW-1:0]  eff;
  logic [IW:0]    i_raw;
  logic [FRAC_BITS-1:0] f_raw;
  logic [IW-1:0]  idx_nxt;
  logic [FRAC_BITS:0] frac_nxt;

  always_comb begin
    if (EW'(size) < EW'(2)) begin
      eff = EW'(2);
    end else if (EW'(size) > EW'(MAXN)) begin
      eff = EW'(MAXN);
    end else begin
      eff = EW'(size);
    end
  end

  // stage 1: unsigned product; negative or zero coordinate gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (coord[COORD_W-1] || coord == '0) begin
        prod_r <= '0;
      end else begin
        prod_r <= PW'(coord[COORD_W-2:0]) * PW'(inv);
      end
      sz1_r <= eff - EW'(1);
    end
  end

  always_comb begin
    pos  = prod_r[PW-1:SH];
    top  = QW'(sz1_r) << FRAC_BITS;
    clip = (pos > top) ? top : pos;
    i_raw = (IW+1)'(clip >> FRAC_BITS);
    f_raw = clip[FRAC_BITS-1:0];
    if (EW'(i_raw) == sz1_r && f_raw == '0) begin
      idx_nxt  = IW'(i_raw - (IW+1)'(1));
      frac_nxt = (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      idx_nxt  = IW'(i_raw);
      frac_nxt = {1'b0, f_raw};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx  <= idx_nxt;
      frac <= frac_nxt;
    end
  end

endmodule

// ===== rtl/core/tgi_front.sv =====
// Front end: classifies items and computes cell and fractions.
module tgi_front #(
  parameter int unsigned MAX_X       = 16,
  parameter int unsigned MAX_Y       = 16,
  parameter int unsigned MAX_Z       = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic                                in_query,
  input  logic signed [tgi_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [tgi_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [tgi_pkg::COORD_W-1:0]  coord_z,
  input  logic [tgi_pkg::SIZE_W-1:0]          size_x,
  input  logic [tgi_pkg::SIZE_W-1:0]          size_y,
  input  logic [tgi_pkg::SIZE_W-1:0]          size_z,
  input  logic [tgi_pkg::INV_W-1:0]           inv_x,
  input  logic [tgi_pkg::INV_W-1:0]           inv_y,
  input  logic [tgi_pkg::INV_W-1:0]           inv_z,
  output logic                                q_valid,
  output logic [$clog2(MAX_X)-1:0]            ix,
  output logic [$clog2(MAX_Y)-1:0]            iy,
  output logic [$clog2(MAX_Z)-1:0]            iz,
  output logic [FRAC_BITS:0]                  fx,
  output logic [FRAC_BITS:0]                  fy,
  output logic [FRAC_BITS:0]                  fz
);
  import tgi_pkg::*;

  logic v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid && in_query;
      v2_r <= v1_r;
    end
  end

  tgi_axis #(.MAXN(MAX_X), .FRAC_BITS(FRAC_BITS)) u_ax (
    .clk(clk), .en(adv), .coord(coord_x), .inv(inv_x), .size(size_x), .idx(ix), .frac(fx));
  tgi_axis #(.MAXN(MAX_Y), .FRAC_BITS(FRAC_BITS)) u_ay (
    .clk(clk), .en(adv), .coord(coord_y), .inv(inv_y), .size(size_y), .idx(iy), .frac(fy));
  tgi_axis #(.MAXN(MAX_Z), .FRAC_BITS(FRAC_BITS)) u_az (
    .clk(clk), .en(adv), .coord(coord_z), .inv(inv_z), .size(size_z), .idx(iz), .frac(fz));

  assign q_valid = v2_r;

endmodule

// ===== rtl/core/tgi_back.sv =====
// Back end: eight parity banks, corner fetch and the seven-lerp blend pipeline.
module tgi_back #(
  parameter int unsigned MAX_X       = 16,
  parameter int unsigned MAX_Y       = 16,
  parameter int unsigned MAX_Z       = 16,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            ld_en,
  input  logic [tgi_pkg::LOAD_W-1:0]      ld_x,
  input  logic [tgi_pkg::LOAD_W-1:0]      ld_y,
  input  logic [tgi_pkg::LOAD_W-1:0]      ld_z,
  input  logic [SAMPLE_BITS-1:0]          ld_val,
  input  logic                            q_valid,
  input  logic [$clog2(MAX_X)-1:0]        ix,
  input  logic [$clog2(MAX_Y)-1:0]        iy,
  input  logic [$clog2(MAX_Z)-1:0]        iz,
  input  logic [FRAC_BITS:0]              fx,
  input  logic [FRAC_BITS:0]              fy,
  input  logic [FRAC_BITS:0]              fz,
  output logic                            r_valid,
  output logic [SAMPLE_BITS-1:0]          r_value
);
  import tgi_pkg::*;

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = $clog2(MAX_Z);
  localparam int unsigned HX = (MAX_X + 1) / 2;
  localparam int unsigned HY = (MAX_Y + 1) / 2;
  localparam int unsigned HZ = (MAX_Z + 1) / 2;
  localparam int unsigned HXW = (HX > 1) ? $clog2(HX) : 1;
  localparam int unsigned HYW = (HY > 1) ? $clog2(HY) : 1;
  localparam int unsigned HZW = (HZ > 1) ? $clog2(HZ) : 1;
  localparam int unsigned BD  = 1 << (HXW + HYW + HZW);
  localparam int unsigned BAW = HXW + HYW + HZW;
  localparam int unsigned DW  = SAMPLE_BITS + 1;
  localparam int unsigned MW  = DW + FRAC_BITS + 1;

  // loads are held one stage so a query accepted just before a load still
  // reads the old entry (its bank read lands on the same edge as the write)
  logic                   ld_v_r;
  logic [LOAD_W-1:0]      ld_x_r, ld_y_r, ld_z_r;
  logic [SAMPLE_BITS-1:0] ld_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_v_r <= 1'b0;
    end else if (adv) begin
      ld_v_r <= ld_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_x_r   <= ld_x;
      ld_y_r   <= ld_y;
      ld_z_r   <= ld_z;
      ld_val_r <= ld_val;
    end
  end

  // load address, widened to cover index bits
  logic [XW:0] lx;
  logic [YW:0] ly;
  logic [ZW:0] lz;
  logic        ld_ok;
  assign lx = (XW+1)'(ld_x_r);
  assign ly = (YW+1)'(ld_y_r);
  assign lz = (ZW+1)'(ld_z_r);
  assign ld_ok = ld_v_r && adv && (32'(ld_x_r) < MAX_X) && (32'(ld_y_r) < MAX_Y)
                 && (32'(ld_z_r) < MAX_Z);

  logic [2:0]     wb;
  logic [BAW-1:0] wa;
  assign wb = {lz[0], ly[0], lx[0]};
  assign wa = {HZW'(lz >> 1), HYW'(ly >> 1), HXW'(lx >> 1)};

  // corner addresses per parity bank
  logic [XW:0] x0, x1;
  logic [YW:0] y0, y1;
  logic [ZW:0] z0, z1;
  assign x0 = (XW+1)'(ix);
  assign x1 = x0 + (XW+1)'(1);
  assign y0 = (YW+1)'(iy);
  assign y1 = y0 + (YW+1)'(1);
  assign z0 = (ZW+1)'(iz);
  assign z1 = z0 + (ZW+1)'(1);

  logic [SAMPLE_BITS-1:0] c_rd [8];
  logic [2:0] par_r;
  logic [FRAC_BITS:0] fx1_r, fy1_r, fz1_r;
  logic v1_r;

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [XW:0] bx;
    logic [YW:0] by;
    logic [ZW:0] bz;
    // bank parity b[i]: pick whichever corner has that parity on the axis
    assign bx = (x0[0] == b[0]) ? x0 : x1;
    assign by = (y0[0] == b[1]) ? y0 : y1;
    assign bz = (z0[0] == b[2]) ? z0 : z1;
    tgi_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BD)) u_ram (
      .clk(clk),
      .we(ld_ok && wb == 3'(b)),
      .waddr(wa),
      .wdata(ld_val_r),
      .re(adv),
      .raddr({HZW'(bz >> 1), HYW'(by >> 1), HXW'(bx >> 1)}),
      .rdata(c_rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      par_r <= {z0[0], y0[0], x0[0]};
      fx1_r <= fx;
      fy1_r <= fy;
      fz1_r <= fz;
    end
  end

  // corner by relative offset (dz,dy,dx): bank = parity xor offset
  logic signed [SAMPLE_BITS-1:0] cn [8];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cn[k] = c_rd[3'(k) ^ par_r];
    end
  end

  // lerp stage: product registered, then add
  // stage A: four x products
  logic signed [SAMPLE_BITS-1:0] a_base_r [4];
  logic signed [MW-1:0]          a_prod_r [4];
  logic [FRAC_BITS:0] fy2_r, fz2_r;
  logic v2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        a_base_r[k] <= cn[2*k];
        a_prod_r[k] <= MW'(DW'(cn[2*k+1]) - DW'(cn[2*k])) * $signed({1'b0, fx1_r});
      end
      fy2_r <= fy1_r;
      fz2_r <= fz1_r;
    end
  end

  logic signed [SAMPLE_BITS-1:0] a_res [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_res[k] = SAMPLE_BITS'(DW'(a_base_r[k]) + DW'(a_prod_r[k] >>> FRAC_BITS));
    end
  end

  logic signed [SAMPLE_BITS-1:0] a_r [4];
  logic [FRAC_BITS:0] fy3_r, fz3_r;
  logic v3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= a_res;
      fy3_r <= fy2_r;
      fz3_r <= fz2_r;
    end
  end

  // stage B: two y lerps (a0,a1) and (a2,a3)
  logic signed [SAMPLE_BITS-1:0] b_base_r [2];
  logic signed [MW-1:0]          b_prod_r [2];
  logic [FRAC_BITS:0] fz4_r;
  logic v4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        b_base_r[k] <= a_r[2*k];
        b_prod_r[k] <= MW'(DW'(a_r[2*k+1]) - DW'(a_r[2*k])) * $signed({1'b0, fy3_r});
      end
      fz4_r <= fz3_r;
    end
  end

  logic signed [SAMPLE_BITS-1:0] b_r [2];
  logic [FRAC_BITS:0] fz5_r;
  logic v5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        b_r[k] <= SAMPLE_BITS'(DW'(b_base_r[k]) + DW'(b_prod_r[k] >>> FRAC_BITS));
      end
      fz5_r <= fz4_r;
    end
  end

  // stage C: z lerp
  logic signed [SAMPLE_BITS-1:0] c_base_r;
  logic signed [MW-1:0]          c_prod_r;
  logic v6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_base_r <= b_r[0];
      c_prod_r <= MW'(DW'(b_r[1]) - DW'(b_r[0])) * $signed({1'b0, fz5_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign r_valid = v6_r;
  assign r_value = SAMPLE_BITS'(DW'(c_base_r) + DW'(c_prod_r >>> FRAC_BITS));

endmodule

// ===== rtl/core/tgi_fifo.sv =====
// Result queue between the compute pipeline and the output port.
module tgi_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [WIDTH-1:0] dout
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic do_pop;

  assign do_pop = pop && cnt_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

  assign empty = cnt_r == '0;
  assign count = cnt_r;
  assign dout  = q_r[rp_r];

endmodule

// ===== rtl/core/trilinear_grid_interpolator.sv =====
// A query's result passes the axis stages, the bank read, the blend stages and
// the queue write before it reaches the queue head.
// Throughput: one item (load or query) per cycle while the result queue has room;
// the pipeline stalls as a whole when its in-flight results could overrun the queue.
// Loads are registered before they write one of eight parity banks.
// Reset (rst_n low, synchronous) empties the pipeline and queue and restores
// registers to sizes 16 and reciprocals 1.0; grid contents are undefined until loaded.
module trilinear_grid_interpolator #(
  parameter int unsigned MAX_X       = tgi_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y       = tgi_pkg::MAX_Y_DEF,
  parameter int unsigned MAX_Z       = tgi_pkg::MAX_Z_DEF,
  parameter int unsigned SAMPLE_BITS = tgi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = tgi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_opcode,
  input  logic signed [tgi_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [tgi_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [tgi_pkg::COORD_W-1:0] in_coord_z,
  input  logic [tgi_pkg::LOAD_W-1:0]         in_load_x,
  input  logic [tgi_pkg::LOAD_W-1:0]         in_load_y,
  input  logic [tgi_pkg::LOAD_W-1:0]         in_load_z,
  input  logic signed [SAMPLE_BITS-1:0]      in_load_value,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [SAMPLE_BITS-1:0]      out_interp_value,
  input  logic                               cfg_we,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgi_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import tgi_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned INFL   = 10;
  localparam int unsigned CW     = $clog2(QDEPTH+1);
  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = $clog2(MAX_Z);

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [INV_W-1:0]  inv_x_r, inv_y_r, inv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RST;
      size_y_r <= SIZE_RST;
      size_z_r <= SIZE_RST;
      inv_x_r  <= INV_RST;
      inv_y_r  <= INV_RST;
      inv_z_r  <= INV_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= cfg_data[SIZE_W-1:0];
        REG_INV_X:  inv_x_r  <= cfg_data[INV_W-1:0];
        REG_INV_Y:  inv_y_r  <= cfg_data[INV_W-1:0];
        REG_INV_Z:  inv_z_r  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // in-flight queries are tracked so the queue can never overflow
  logic [CW-1:0] q_count;
  logic [3:0]    infl_r;
  logic          adv, acc, r_valid, pop_ok;
  logic          q_valid;
  logic [XW-1:0] ix;
  logic [YW-1:0] iy;
  logic [ZW-1:0] iz;
  logic [FRAC_BITS:0] fx, fy, fz;
  logic [SAMPLE_BITS-1:0] r_value;

  assign adv  = (32'(q_count) + 32'(infl_r)) < QDEPTH;
  assign full = !adv;
  assign acc  = push && adv;
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
    end else if (adv) begin
      infl_r <= infl_r + 4'(acc && in_opcode == OP_QUERY) - 4'(r_valid);
    end
  end

  tgi_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(acc), .in_query(in_opcode == OP_QUERY),
    .coord_x(in_coord_x), .coord_y(in_coord_y), .coord_z(in_coord_z),
    .size_x(size_x_r), .size_y(size_y_r), .size_z(size_z_r),
    .inv_x(inv_x_r), .inv_y(inv_y_r), .inv_z(inv_z_r),
    .q_valid(q_valid), .ix(ix), .iy(iy), .iz(iz), .fx(fx), .fy(fy), .fz(fz)
  );

  tgi_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z),
             .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .ld_en(acc && in_opcode == OP_LOAD),
    .ld_x(in_load_x), .ld_y(in_load_y), .ld_z(in_load_z), .ld_val(in_load_value),
    .q_valid(q_valid), .ix(ix), .iy(iy), .iz(iz), .fx(fx), .fy(fy), .fz(fz),
    .r_valid(r_valid), .r_value(r_value)
  );

  tgi_fifo #(.WIDTH(SAMPLE_BITS), .DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(adv && r_valid), .din(r_value),
    .pop(pop_ok), .empty(empty), .count(q_count), .dout(out_interp_value)
  );

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_count) + 32'(infl_r) <= QDEPTH) else $error("result queue overcommitted");
  a_infl: assert property (@(posedge clk) disable iff (!rst_n)
    32'(infl_r) <= INFL) else $error("in-flight count out of range");
  a_nopush_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(u_fifo.push)) else $error("result written while stalled");

endmodule
